>>> src/scba_pkg.sv
// Shared types and constants for the size-class block allocator.
`default_nettype none

package scba_pkg;

   // Pool geometry
   localparam int NUM_CLASSES = 3;
   localparam int MAX_CLASSES = 3;
   localparam int CLASS_BLOCKS [MAX_CLASSES] = '{50, 10, 5};
   localparam int LINK_W      = 6;
   localparam int BYTES_W     = 24;
   localparam int REQ_W       = 32;
   localparam int CLASS_W     = 2;
   localparam int STATUS_W    = 3;
   localparam int CSR_IDX_W   = 2;

   // Block size registers after reset
   localparam logic [BYTES_W-1:0] BYTES_RESET [MAX_CLASSES] =
      '{24'd4096, 24'd40960, 24'd102400};

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SMALL_BYTES  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MEDIUM_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LARGE_BYTES  = 2'd2;

   // Commands
   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // Class code that stands for the heap
   localparam logic [CLASS_W-1:0] HEAP_CLASS = 2'd3;
   localparam logic [LINK_W-1:0]  NO_BLOCK   = 6'd0;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED      = 3'd0,
      ST_CLASS_EMPTY  = 3'd1,
      ST_TOO_LARGE    = 3'd2,
      ST_POOL_RETURN  = 3'd3,
      ST_HEAP_RELEASE = 3'd4,
      ST_INVALID      = 3'd5
   } status_type;

   // Class selection result for an allocate
   typedef struct packed {
      logic               fit;
      logic [CLASS_W-1:0] cls;
   } class_sel_type;

endpackage

`default_nettype wire

>>> src/scba_link_ram.sv
// Next-link memory of one size class, registered read with write forwarding.
`default_nettype none

module scba_link_ram #(
   parameter int DEPTH = 50
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                wr_en,
   input  wire logic [$clog2(DEPTH+1)-1:0]          wr_addr,
   input  wire logic [scba_pkg::LINK_W-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH+1)-1:0]          rd_addr,
   output logic      [scba_pkg::LINK_W-1:0]         rd_data
);

   localparam int AW = $clog2(DEPTH + 1);
   localparam int LW = scba_pkg::LINK_W;

   // Entry 0 is never addressed by a live block; blocks are 1..DEPTH
   logic [LW-1:0] mem [0:DEPTH];
   logic [DEPTH:0] written_ff;
   logic [LW-1:0] mem_q_ff;
   logic [AW-1:0] rd_addr_ff;
   logic          use_mem_ff;
   logic          hit_ff;
   logic [LW-1:0] hit_data_ff;
   logic [LW-1:0] init_link;

   // Array storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q_ff    <= mem[rd_addr];
      rd_addr_ff  <= rd_addr;
      hit_data_ff <= wr_data;
   end

   // Written flags: unwritten entries read as the initial chain
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         use_mem_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         use_mem_ff <= written_ff[rd_addr];
         hit_ff     <= wr_en && (wr_addr == rd_addr);
      end
   end

   // Block k links to k+1, the last block ends the list
   assign init_link = (rd_addr_ff < AW'(DEPTH)) ? (LW'(rd_addr_ff) + LW'(1)) : '0;

   assign rd_data = hit_ff ? hit_data_ff : (use_mem_ff ? mem_q_ff : init_link);

endmodule

`default_nettype wire

>>> src/scba_class_sel.sv
// Picks the first present size class whose block size covers a request.
`default_nettype none

module scba_class_sel (
   input  wire logic [scba_pkg::REQ_W-1:0]   request_bytes,
   input  wire logic [scba_pkg::BYTES_W-1:0] block_bytes [scba_pkg::MAX_CLASSES],
   output scba_pkg::class_sel_type           sel
);

   localparam int RW = scba_pkg::REQ_W;
   localparam int CW = scba_pkg::CLASS_W;

   // Walk from the last class down so the lowest fitting class wins
   always_comb begin
      sel.fit = 1'b0;
      sel.cls = '0;
      for (int c = scba_pkg::NUM_CLASSES - 1; c >= 0; c--) begin
         if (request_bytes <= RW'(block_bytes[c])) begin
            sel.fit = 1'b1;
            sel.cls = CW'(c);
         end
      end
   end

endmodule

`default_nettype wire

>>> src/size_class_block_allocator_core.sv
// Top level of the size-class block allocator.
// One transaction is taken per cycle while req_stall is low and answered with one result in the cycle after;
// the result register frees the input side whenever the result is taken or absent.
// Each class keeps its free-list head in a register and the link of that head
// prefetched from its link memory, so pops and pushes of any class run back to back
// with no bubble. Link memories start out as the full chain of blocks without a
// clearing pass. Block size registers may be written while no transaction is open.
`default_nettype none

module size_class_block_allocator_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_command,
   input  wire logic [scba_pkg::REQ_W-1:0]        req_request_bytes,
   input  wire logic [scba_pkg::CLASS_W-1:0]      req_release_class,
   input  wire logic [scba_pkg::LINK_W-1:0]       req_release_block,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [scba_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [scba_pkg::CLASS_W-1:0]      rsp_grant_class,
   output logic      [scba_pkg::LINK_W-1:0]       rsp_grant_block,
   // register write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [scba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [scba_pkg::BYTES_W-1:0]      csr_data
);

   localparam int NC = scba_pkg::NUM_CLASSES;
   localparam int LW = scba_pkg::LINK_W;
   localparam int CW = scba_pkg::CLASS_W;

   logic [scba_pkg::BYTES_W-1:0] block_bytes_ff [scba_pkg::MAX_CLASSES];
   logic [LW-1:0]                head_ff [NC];
   logic [LW-1:0]                head_in [NC];
   logic [LW-1:0]                link_q  [NC];
   logic [NC-1:0]                link_we;
   logic [LW-1:0]                ram_rd_addr [NC];

   logic                         rsp_valid_ff, rsp_valid_in;
   scba_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [CW-1:0]                rsp_class_ff, rsp_class_in;
   logic [LW-1:0]                rsp_block_ff, rsp_block_in;

   scba_pkg::class_sel_type      sel;
   logic                         accept;
   logic [LW-1:0]                rel_count;

   // Handshakes
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Block size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < scba_pkg::MAX_CLASSES; c++) begin
            block_bytes_ff[c] <= scba_pkg::BYTES_RESET[c];
         end
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            scba_pkg::REG_SMALL_BYTES:  block_bytes_ff[0] <= csr_data;
            scba_pkg::REG_MEDIUM_BYTES: block_bytes_ff[1] <= csr_data;
            scba_pkg::REG_LARGE_BYTES:  block_bytes_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   scba_class_sel u_class_sel (
      .request_bytes (req_request_bytes),
      .block_bytes   (block_bytes_ff),
      .sel           (sel)
   );

   // Link memories, one per class, read at the next head every cycle
   for (genvar g = 0; g < NC; g++) begin : g_class
      localparam int AW = $clog2(scba_pkg::CLASS_BLOCKS[g] + 1);

      assign ram_rd_addr[g] = reset ? LW'(1) : head_in[g];

      scba_link_ram #(
         .DEPTH (scba_pkg::CLASS_BLOCKS[g])
      ) u_link_ram (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (link_we[g]),
         .wr_addr (req_release_block[AW-1:0]),
         .wr_data (head_ff[g]),
         .rd_addr (ram_rd_addr[g][AW-1:0]),
         .rd_data (link_q[g])
      );
   end

   assign rel_count = (req_release_class < CW'(NC))
                      ? LW'(scba_pkg::CLASS_BLOCKS[req_release_class]) : '0;

   // Pop or push and build the result
   always_comb begin
      for (int c = 0; c < NC; c++) begin
         head_in[c] = head_ff[c];
      end
      link_we       = '0;
      rsp_status_in = rsp_status_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_block_in  = rsp_block_ff;
      if (accept) begin
         if (req_command == scba_pkg::CMD_ALLOC) begin
            rsp_class_in = scba_pkg::HEAP_CLASS;
            rsp_block_in = scba_pkg::NO_BLOCK;
            if (!sel.fit) begin
               rsp_status_in = scba_pkg::ST_TOO_LARGE;
            end else if (head_ff[sel.cls] != scba_pkg::NO_BLOCK) begin
               rsp_status_in        = scba_pkg::ST_GRANTED;
               rsp_class_in         = sel.cls;
               rsp_block_in         = head_ff[sel.cls];
               head_in[sel.cls]     = link_q[sel.cls];
            end else begin
               rsp_status_in = scba_pkg::ST_CLASS_EMPTY;
            end
         end else begin
            rsp_class_in = '0;
            rsp_block_in = scba_pkg::NO_BLOCK;
            if (req_release_class == scba_pkg::HEAP_CLASS ||
                req_release_block == scba_pkg::NO_BLOCK) begin
               rsp_status_in = scba_pkg::ST_HEAP_RELEASE;
            end else if (req_release_class >= CW'(NC) || req_release_block > rel_count) begin
               rsp_status_in = scba_pkg::ST_INVALID;
            end else begin
               rsp_status_in                = scba_pkg::ST_POOL_RETURN;
               link_we[req_release_class]   = 1'b1;
               head_in[req_release_class]   = req_release_block;
            end
         end
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   // Free-list heads and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NC; c++) begin
            head_ff[c] <= LW'(1);
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_block_ff  <= rsp_block_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_grant_class = rsp_class_ff;
   assign rsp_grant_block = rsp_block_ff;

   // Checks
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction produced no result");

   a_grant_has_block: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == scba_pkg::ST_GRANTED) |->
         (rsp_grant_block != scba_pkg::NO_BLOCK && rsp_grant_class != scba_pkg::HEAP_CLASS))
      else $error("grant without a pool block");

   for (genvar g = 0; g < NC; g++) begin : g_chk
      a_head_in_range: assert property (@(posedge clock) disable iff (reset)
         head_ff[g] <= LW'(scba_pkg::CLASS_BLOCKS[g]))
         else $error("free-list head beyond class block count");
   end

endmodule

`default_nettype wire

>>> tb/size_class_block_allocator_core_test.sv
// Self-checking testbench for the size-class block allocator core.

typedef struct packed {
   scba_pkg::status_type          status;
   logic [scba_pkg::CLASS_W-1:0]  cls;
   logic [scba_pkg::LINK_W-1:0]   blk;
} alloc_result_type;

// Tracks the free lists and block sizes, and checks results in order
class free_list_tracker;
   localparam int LINK_DEPTH  = scba_pkg::CLASS_BLOCKS[0] + scba_pkg::CLASS_BLOCKS[1] +
                                scba_pkg::CLASS_BLOCKS[2];
   localparam int MAX_REPORTS = 10;

   logic [scba_pkg::BYTES_W-1:0] block_bytes [scba_pkg::MAX_CLASSES];
   logic [scba_pkg::LINK_W-1:0]  free_head [scba_pkg::MAX_CLASSES];
   logic [scba_pkg::LINK_W-1:0]  next_link [LINK_DEPTH];
   alloc_result_type             awaited_results [$];
   int                           failures;

   // Lists start as full chains 1 -> 2 -> ... -> last -> end
   function new();
      int slot;
      slot = 0;
      failures = 0;
      for (int c = 0; c < scba_pkg::MAX_CLASSES; c++) begin
         block_bytes[c] = scba_pkg::BYTES_RESET[c];
         free_head[c] = scba_pkg::LINK_W'(1);
         for (int k = 1; k <= scba_pkg::CLASS_BLOCKS[c]; k++) begin
            next_link[slot] = (k < scba_pkg::CLASS_BLOCKS[c]) ? scba_pkg::LINK_W'(k + 1)
                                                              : scba_pkg::NO_BLOCK;
            slot++;
         end
      end
   endfunction

   // Flat link slot of block b of class c
   function int link_slot(int c, int b);
      int base;
      base = 0;
      for (int k = 0; k < c; k++) base += scba_pkg::CLASS_BLOCKS[k];
      return base + b - 1;
   endfunction

   function void write_register(logic [scba_pkg::CSR_IDX_W-1:0] idx,
                                logic [scba_pkg::BYTES_W-1:0] data);
      case (idx)
         scba_pkg::REG_SMALL_BYTES:  block_bytes[0] = data;
         scba_pkg::REG_MEDIUM_BYTES: block_bytes[1] = data;
         scba_pkg::REG_LARGE_BYTES:  block_bytes[2] = data;
         default: ;
      endcase
   endfunction

   // Update list state for an accepted transaction and queue its result
   function alloc_result_type predict_transaction(logic cmd,
                                                  logic [scba_pkg::REQ_W-1:0] bytes,
                                                  logic [scba_pkg::CLASS_W-1:0] rcls,
                                                  logic [scba_pkg::LINK_W-1:0] rblk);
      alloc_result_type res;
      logic [scba_pkg::LINK_W-1:0] head;
      bit chosen;
      chosen = 1'b0;
      res.status = scba_pkg::ST_TOO_LARGE;
      res.cls = scba_pkg::HEAP_CLASS;
      res.blk = scba_pkg::NO_BLOCK;
      if (cmd == scba_pkg::CMD_ALLOC) begin
         // first class big enough wins, even if its list is empty
         for (int c = 0; c < scba_pkg::NUM_CLASSES; c++) begin
            if (!chosen && bytes <= scba_pkg::REQ_W'(block_bytes[c])) begin
               chosen = 1'b1;
               head = free_head[c];
               if (head != scba_pkg::NO_BLOCK && int'(head) <= scba_pkg::CLASS_BLOCKS[c]) begin
                  free_head[c] = next_link[link_slot(c, int'(head))];
                  res.status = scba_pkg::ST_GRANTED;
                  res.cls = scba_pkg::CLASS_W'(c);
                  res.blk = head;
               end else begin
                  res.status = scba_pkg::ST_CLASS_EMPTY;
               end
            end
         end
      end else begin
         res.cls = '0;
         if (rcls == scba_pkg::HEAP_CLASS || rblk == scba_pkg::NO_BLOCK) begin
            res.status = scba_pkg::ST_HEAP_RELEASE;
         end else if (int'(rcls) >= scba_pkg::NUM_CLASSES ||
                      int'(rblk) > scba_pkg::CLASS_BLOCKS[rcls]) begin
            res.status = scba_pkg::ST_INVALID;
         end else begin
            // push onto the head; repeated releases are not filtered
            next_link[link_slot(int'(rcls), int'(rblk))] = free_head[rcls];
            free_head[rcls] = rblk;
            res.status = scba_pkg::ST_POOL_RETURN;
         end
      end
      awaited_results = {awaited_results, res};
      return res;
   endfunction

   function void check_result(logic [scba_pkg::STATUS_W-1:0] status,
                              logic [scba_pkg::CLASS_W-1:0] cls,
                              logic [scba_pkg::LINK_W-1:0] blk);
      alloc_result_type want;
      if (awaited_results.size() == 0) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $display("ERROR: result with none pending: status %0d class %0d block %0d",
                     status, cls, blk);
         return;
      end
      want = awaited_results.pop_front();
      if (status !== want.status || cls !== want.cls || blk !== want.blk) begin
         failures++;
         if (failures <= MAX_REPORTS)
            $display("ERROR: expected status %0d class %0d block %0d, got %0d %0d %0d",
                     want.status, want.cls, want.blk, status, cls, blk);
      end
   endfunction

   function int pending();
      return awaited_results.size();
   endfunction
endclass

module size_class_block_allocator_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int END_CYCLES  = 8;
   localparam logic [scba_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [scba_pkg::CLASS_W-1:0] cls;
      logic [scba_pkg::LINK_W-1:0]  blk;
   } held_block_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_command = scba_pkg::CMD_ALLOC;
   logic [scba_pkg::REQ_W-1:0]      req_request_bytes = '0;
   logic [scba_pkg::CLASS_W-1:0]    req_release_class = '0;
   logic [scba_pkg::LINK_W-1:0]     req_release_block = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [scba_pkg::STATUS_W-1:0]   rsp_status;
   logic [scba_pkg::CLASS_W-1:0]    rsp_grant_class;
   logic [scba_pkg::LINK_W-1:0]     rsp_grant_block;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [scba_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [scba_pkg::BYTES_W-1:0]    csr_data = '0;

   free_list_tracker tracker;
   held_block_type   granted_blocks [$];
   bit               sender_idling = 1'b1;
   bit               rsp_idling = 1'b1;
   int               hold_off_cycles = 0;
   int               stall_left = 0;
   int unsigned      cycle_count = 0;

   size_class_block_allocator_core u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("size_class_block_allocator_core test failed");
         $finish;
      end
   end

   // Mostly short idle stretches, a few long ones
   function automatic int idle_length();
      return ($urandom_range(99) < 85) ? int'($urandom_range(3, 1)) : int'($urandom_range(40, 10));
   endfunction

   // Result side: check each taken transaction, then pick the next stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            tracker.check_result(rsp_status, rsp_grant_class, rsp_grant_block);
         if (stall_left == 0) begin
            if (hold_off_cycles != 0) begin
               stall_left = hold_off_cycles;
               hold_off_cycles = 0;
            end else if (rsp_idling && $urandom_range(99) < 30) begin
               stall_left = idle_length();
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Request sizes clustered around the configured block sizes
   function automatic logic [scba_pkg::REQ_W-1:0] pick_request_bytes();
      logic [scba_pkg::REQ_W-1:0] size;
      size = scba_pkg::REQ_W'(tracker.block_bytes[$urandom_range(scba_pkg::NUM_CLASSES - 1)]);
      case ($urandom_range(7))
         0: return size;
         1: return size + 1;
         3: return '0;
         4: return $urandom;
         5: return scba_pkg::REQ_W'($urandom_range(255));
         default: return scba_pkg::REQ_W'($urandom_range(size));
      endcase
   endfunction

   task automatic sender_pause();
      int n;
      if (sender_idling && $urandom_range(99) < 30) begin
         n = idle_length();
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Offer one transaction, predict it once taken, keep the granted set current
   task automatic issue_transaction(logic cmd, logic [scba_pkg::REQ_W-1:0] bytes,
                                    logic [scba_pkg::CLASS_W-1:0] rcls,
                                    logic [scba_pkg::LINK_W-1:0] rblk);
      alloc_result_type res;
      held_block_type hb;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_request_bytes <= bytes;
      req_release_class <= rcls;
      req_release_block <= rblk;
      do @(posedge clock); while (req_stall);
      res = tracker.predict_transaction(cmd, bytes, rcls, rblk);
      if (res.status == scba_pkg::ST_GRANTED) begin
         hb.cls = res.cls;
         hb.blk = res.blk;
         granted_blocks = {granted_blocks, hb};
      end else if (res.status == scba_pkg::ST_POOL_RETURN) begin
         for (int i = 0; i < granted_blocks.size(); i++) begin
            if (granted_blocks[i].cls == rcls && granted_blocks[i].blk == rblk) begin
               granted_blocks.delete(i);
               break;
            end
         end
      end
      sender_pause();
   endtask

   // Unused fields of each command carry random bits
   task automatic alloc_item(logic [scba_pkg::REQ_W-1:0] bytes);
      issue_transaction(scba_pkg::CMD_ALLOC, bytes, scba_pkg::CLASS_W'($urandom),
                        scba_pkg::LINK_W'($urandom));
   endtask

   task automatic release_item(logic [scba_pkg::CLASS_W-1:0] rcls,
                               logic [scba_pkg::LINK_W-1:0] rblk);
      issue_transaction(scba_pkg::CMD_RELEASE, $urandom, rcls, rblk);
   endtask

   task automatic random_transaction(int alloc_pct, bit allow_double);
      int roll;
      held_block_type hb;
      logic [scba_pkg::CLASS_W-1:0] c;
      roll = $urandom_range(99);
      if (roll < alloc_pct) begin
         alloc_item(pick_request_bytes());
      end else if (granted_blocks.size() != 0 && roll < 95) begin
         // well-formed: give back a block that is out
         hb = granted_blocks[$urandom_range(granted_blocks.size() - 1)];
         release_item(hb.cls, hb.blk);
      end else if (allow_double && roll < 98) begin
         c = scba_pkg::CLASS_W'($urandom_range(scba_pkg::NUM_CLASSES - 1));
         release_item(c, scba_pkg::LINK_W'($urandom_range(scba_pkg::CLASS_BLOCKS[c], 1)));
      end else begin
         // heap, zero-block and out-of-range releases leave the lists alone
         case ($urandom_range(2))
            0: release_item(scba_pkg::HEAP_CLASS, scba_pkg::LINK_W'($urandom));
            1: release_item(scba_pkg::CLASS_W'($urandom), scba_pkg::NO_BLOCK);
            default: begin
               c = scba_pkg::CLASS_W'($urandom_range(scba_pkg::NUM_CLASSES - 1));
               release_item(c, scba_pkg::LINK_W'($urandom_range((1 << scba_pkg::LINK_W) - 1,
                                                   scba_pkg::CLASS_BLOCKS[c] + 1)));
            end
         endcase
      end
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // Write all block sizes in one burst, optionally touching the unused index
   task automatic program_block_sizes(logic [scba_pkg::BYTES_W-1:0] class0_bytes,
                                      logic [scba_pkg::BYTES_W-1:0] class1_bytes,
                                      logic [scba_pkg::BYTES_W-1:0] class2_bytes,
                                      bit poke_unused);
      logic [scba_pkg::BYTES_W-1:0]   values [4];
      logic [scba_pkg::CSR_IDX_W-1:0] indexes [4];
      int n;
      values[0] = class0_bytes;
      values[1] = class1_bytes;
      values[2] = class2_bytes;
      values[3] = scba_pkg::BYTES_W'($urandom);
      indexes[0] = scba_pkg::REG_SMALL_BYTES;
      indexes[1] = scba_pkg::REG_MEDIUM_BYTES;
      indexes[2] = scba_pkg::REG_LARGE_BYTES;
      indexes[3] = REG_UNUSED;
      n = poke_unused ? 4 : 3;
      for (int i = 0; i < n; i++) begin
         csr_valid <= 1'b1;
         csr_index <= indexes[i];
         csr_data <= values[i];
         do @(posedge clock); while (!csr_ready);
         tracker.write_register(indexes[i], values[i]);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      int b0;
      int b1;
      tracker = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: size edges, exhaustion, LIFO order, heap and invalid releases
      alloc_item(0);
      alloc_item(32'd4096);
      alloc_item(32'd4097);
      alloc_item(32'd40961);
      alloc_item(32'd102400);
      alloc_item(32'd102401);
      alloc_item(32'hFFFF_FFFF);
      repeat (3) alloc_item(32'd102400);
      alloc_item(32'd50000);
      release_item(2'd2, 6'd5);
      alloc_item(32'd60000);
      release_item(scba_pkg::HEAP_CLASS, 6'd7);
      release_item(2'd1, scba_pkg::NO_BLOCK);
      release_item(2'd0, 6'd51);
      release_item(2'd1, 6'd11);
      release_item(2'd2, 6'd63);
      release_item(2'd0, 6'd1);
      release_item(2'd0, 6'd2);
      alloc_item(32'd1);
      release_item(2'd1, 6'd1);
      wait_all_results();

      // Reset sizes, random traffic with idling on both sides
      repeat (300) random_transaction(60, 1'b0);
      wait_all_results();

      // Minimum sizes for classes 0 and 1, no idling
      program_block_sizes(24'd1, 24'd1, 24'hFF_FFFF, 1'b1);
      sender_idling = 1'b0;
      rsp_idling = 1'b0;
      repeat (250) random_transaction(55, 1'b0);

      // Receiver holds off while transactions keep coming
      hold_off_cycles = 150;
      repeat (40) random_transaction(50, 1'b0);
      wait_all_results();

      // Maximum sizes: class 0 takes nearly everything
      program_block_sizes(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b0);
      sender_idling = 1'b1;
      rsp_idling = 1'b1;
      repeat (250) random_transaction(50, 1'b0);
      wait_all_results();

      // Random ascending sizes, allocation heavy to drain the lists
      b0 = $urandom_range(5000, 1);
      b1 = b0 + $urandom_range(100000, 1);
      program_block_sizes(scba_pkg::BYTES_W'(b0), scba_pkg::BYTES_W'(b1),
                          scba_pkg::BYTES_W'(b1 + $urandom_range(1000000, 1)), 1'b0);
      repeat (300) random_transaction(70, 1'b0);
      wait_all_results();

      // Out-of-order sizes, release heavy to refill
      program_block_sizes(scba_pkg::BYTES_W'($urandom_range(200000, 50000)),
                          scba_pkg::BYTES_W'($urandom_range(4096, 1)), 24'hFF_FFFF, 1'b1);
      repeat (300) random_transaction(35, 1'b0);
      wait_all_results();

      // All classes at one byte
      program_block_sizes(24'd1, 24'd1, 24'd1, 1'b0);
      repeat (100) random_transaction(60, 1'b0);
      wait_all_results();

      // Random sizes, then repeated releases corrupt the lists on purpose
      program_block_sizes(scba_pkg::BYTES_W'($urandom_range(24'hFF_FFFF, 1)),
                          scba_pkg::BYTES_W'($urandom_range(24'hFF_FFFF, 1)),
                          scba_pkg::BYTES_W'($urandom_range(24'hFF_FFFF, 1)), 1'b0);
      release_item(2'd2, 6'd1);
      release_item(2'd2, 6'd1);
      repeat (200) random_transaction(50, 1'b1);
      wait_all_results();

      repeat (END_CYCLES) @(posedge clock);
      if (tracker.failures == 0) begin
         $display("size_class_block_allocator_core test passed");
      end else begin
         $display("size_class_block_allocator_core test failed");
      end
      $finish;
   end
endmodule
